// ===== hw/rtl/wpmh_pkg.sv =====
// ----------------------------------------------------------------------------
// wpmh_pkg
// shared types, codes and the priority function of the weighted max-heap
// ----------------------------------------------------------------------------
package wpmh_pkg;

  localparam int CAPACITY = 64;

  localparam int AGE_W   = 8;
  localparam int TAG_W   = 31;
  localparam int PRIO_W  = 9;
  localparam int COUNT_W = 7;

  localparam logic [PRIO_W-1:0] FLAG_WEIGHT = PRIO_W'(50);

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_EXTRACTED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic [TAG_W-1:0] tag;
    logic             comorb;
    logic             risk;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic             operation;
    logic [AGE_W-1:0] age;
    logic [TAG_W-1:0] contact_tag;
    logic             has_comorbidity;
    logic             risk_area;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [AGE_W-1:0]   out_age;
    logic [TAG_W-1:0]   out_contact_tag;
    logic               out_comorbidity;
    logic               out_risk_area;
    logic [COUNT_W-1:0] entry_count;
  } out_t;

  // result of one pass through the shared compare unit
  typedef struct packed {
    logic pick_right;
    logic move_wins;
    rec_t child;
  } cmp_res_t;

  function automatic logic [PRIO_W-1:0] prio_of(input rec_t r);
    logic [PRIO_W-1:0] p;
    p = PRIO_W'(r.age);
    if (r.comorb) p = p + FLAG_WEIGHT;
    if (r.risk)   p = p + FLAG_WEIGHT;
    return p;
  endfunction

endpackage

// ===== hw/rtl/wpmh_ram.sv =====
// ----------------------------------------------------------------------------
// wpmh_ram
// generic ram, one write port, two read ports with registered read data
// ----------------------------------------------------------------------------
module wpmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== hw/rtl/wpmh_cmp.sv =====
// ----------------------------------------------------------------------------
// wpmh_cmp
// shared priority compare unit: picks a child and tests the moving entry
// ----------------------------------------------------------------------------
module wpmh_cmp (
  input  wpmh_pkg::rec_t     mov,
  input  wpmh_pkg::rec_t     left,
  input  wpmh_pkg::rec_t     right,
  input  logic               right_ok,
  output wpmh_pkg::cmp_res_t res
);

  logic [wpmh_pkg::PRIO_W-1:0] p_mov;
  logic [wpmh_pkg::PRIO_W-1:0] p_left;
  logic [wpmh_pkg::PRIO_W-1:0] p_right;
  logic [wpmh_pkg::PRIO_W-1:0] p_child;

  always_comb begin
    p_mov   = wpmh_pkg::prio_of(mov);
    p_left  = wpmh_pkg::prio_of(left);
    p_right = wpmh_pkg::prio_of(right);
    // right child only when it exists and is strictly greater
    res.pick_right = right_ok && (p_right > p_left);
    res.child      = res.pick_right ? right : left;
    p_child        = res.pick_right ? p_right : p_left;
    res.move_wins  = p_mov > p_child;
  end

endmodule

// ===== hw/rtl/weighted_priority_max_heap_unit.sv =====
// ----------------------------------------------------------------------------
// weighted_priority_max_heap_unit
// binary max-heap priority queue, records sift through a single-port-write ram
// ----------------------------------------------------------------------------
// sequence: rejected inserts, empty extracts and inserts at an empty heap go straight to the result;
//   other inserts climb through a read and a compare step per level, with a final write at the root,
//   extracts load the root and tail, then descend through read and compare steps to a leaf or a stop
// throughput: one word at a time, the next word is taken the cycle after the result
//   loads; a stalled output holds the sequencer in its result state
// reset: rst_n synchronous, empties the heap; ram contents are not cleared
// ----------------------------------------------------------------------------
module weighted_priority_max_heap_unit #(
  parameter int CAPACITY = wpmh_pkg::CAPACITY
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  wpmh_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output wpmh_pkg::out_t  out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int CW = AW + 2;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UP_RD  = 8'b0000_0010,
    S_UP_CMP = 8'b0000_0100,
    S_UP_FIN = 8'b0000_1000,
    S_DN_LD  = 8'b0001_0000,
    S_DN_RD  = 8'b0010_0000,
    S_DN_CMP = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [OW-1:0]       occ_r, occ_nxt;      // entries held
  logic [AW-1:0]       pos_r, pos_nxt;      // current hole in the heap
  wpmh_pkg::rec_t      mov_r, mov_nxt;      // record being sifted
  wpmh_pkg::out_t      res_r, res_nxt;      // pending result word
  wpmh_pkg::out_t      out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  // ram ports
  logic                we;
  logic [AW-1:0]       waddr;
  wpmh_pkg::rec_t      wdata;
  logic [AW-1:0]       raddr_a;
  logic [AW-1:0]       raddr_b;
  logic [wpmh_pkg::REC_W-1:0] rdata_a;
  logic [wpmh_pkg::REC_W-1:0] rdata_b;

  // compare unit
  wpmh_pkg::rec_t      cmp_left;
  wpmh_pkg::rec_t      cmp_right;
  logic                cmp_right_ok;
  wpmh_pkg::cmp_res_t  cmp_res;

  // heap index arithmetic
  logic [CW-1:0]       lchild;
  logic [CW-1:0]       rchild;
  logic [AW-1:0]       parent;
  logic                in_fire;
  wpmh_pkg::rec_t      in_rec;

  assign in_fire = in_valid && in_ready;
  assign lchild  = CW'({pos_r, 1'b1});
  assign rchild  = lchild + CW'(1);
  assign parent  = (pos_r - AW'(1)) >> 1;

  assign in_rec.age    = in_data.age;
  assign in_rec.tag    = in_data.contact_tag;
  assign in_rec.comorb = in_data.has_comorbidity;
  assign in_rec.risk   = in_data.risk_area;

  assign cmp_left     = wpmh_pkg::rec_t'(rdata_a);
  assign cmp_right    = wpmh_pkg::rec_t'(rdata_b);
  assign cmp_right_ok = (state_r == S_DN_CMP) && (rchild < CW'(occ_r));

  wpmh_ram #(
    .WIDTH (wpmh_pkg::REC_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  wpmh_cmp u_cmp (
    .mov      (mov_r),
    .left     (cmp_left),
    .right    (cmp_right),
    .right_ok (cmp_right_ok),
    .res      (cmp_res)
  );

  // new word only while idle; the output register decouples the consumer
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    pos_nxt       = pos_r;
    mov_nxt       = mov_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    we            = 1'b0;
    waddr         = pos_r;
    wdata         = mov_r;
    raddr_a       = parent;
    raddr_b       = AW'(rchild);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt = '0;
          if (in_data.operation == wpmh_pkg::OP_INSERT) begin
            if (occ_r == OW'(CAPACITY)) begin
              res_nxt.status      = wpmh_pkg::ST_FULL;
              res_nxt.entry_count = wpmh_pkg::COUNT_W'(occ_r);
              state_nxt           = S_OUT;
            end else begin
              // new record starts at the tail slot
              mov_nxt             = in_rec;
              pos_nxt             = AW'(occ_r);
              occ_nxt             = occ_r + OW'(1);
              res_nxt.status      = wpmh_pkg::ST_INSERTED;
              res_nxt.entry_count = wpmh_pkg::COUNT_W'(occ_r + OW'(1));
              if (occ_r == '0) begin
                we        = 1'b1;
                waddr     = '0;
                wdata     = in_rec;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_UP_RD;
              end
            end
          end else begin
            if (occ_r == '0) begin
              res_nxt.status = wpmh_pkg::ST_EMPTY;
              state_nxt      = S_OUT;
            end else begin
              // fetch root and tail together
              raddr_a             = '0;
              raddr_b             = AW'(occ_r - OW'(1));
              occ_nxt             = occ_r - OW'(1);
              res_nxt.status      = wpmh_pkg::ST_EXTRACTED;
              res_nxt.entry_count = wpmh_pkg::COUNT_W'(occ_r - OW'(1));
              state_nxt           = S_DN_LD;
            end
          end
        end
      end

      S_UP_RD: begin
        raddr_a   = parent;
        state_nxt = S_UP_CMP;
      end

      S_UP_CMP: begin
        we = 1'b1;
        if (cmp_res.move_wins) begin
          // parent drops into the hole, hole climbs
          waddr   = pos_r;
          wdata   = cmp_left;
          pos_nxt = parent;
          if (parent == '0) begin
            state_nxt = S_UP_FIN;
          end else begin
            state_nxt = S_UP_RD;
          end
        end else begin
          waddr     = pos_r;
          wdata     = mov_r;
          state_nxt = S_OUT;
        end
      end

      S_UP_FIN: begin
        we        = 1'b1;
        waddr     = pos_r;
        wdata     = mov_r;
        state_nxt = S_OUT;
      end

      S_DN_LD: begin
        res_nxt.out_age         = cmp_left.age;
        res_nxt.out_contact_tag = cmp_left.tag;
        res_nxt.out_comorbidity = cmp_left.comorb;
        res_nxt.out_risk_area   = cmp_left.risk;
        mov_nxt                 = cmp_right;
        pos_nxt                 = '0;
        state_nxt               = S_DN_RD;
      end

      S_DN_RD: begin
        raddr_a = AW'(lchild);
        raddr_b = AW'(rchild);
        if (lchild < CW'(occ_r)) begin
          state_nxt = S_DN_CMP;
        end else begin
          // leaf reached, settle the moving record
          we        = 1'b1;
          waddr     = pos_r;
          wdata     = mov_r;
          state_nxt = S_OUT;
        end
      end

      S_DN_CMP: begin
        we = 1'b1;
        if (cmp_res.move_wins) begin
          waddr     = pos_r;
          wdata     = mov_r;
          state_nxt = S_OUT;
        end else begin
          // equal priority swaps too
          waddr     = pos_r;
          wdata     = cmp_res.child;
          pos_nxt   = cmp_res.pick_right ? AW'(rchild) : AW'(lchild);
          state_nxt = S_DN_RD;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    mov_r <= mov_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // occupancy stays within the heap size
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(CAPACITY))
    else $error("heap occupancy above capacity");

  // occupancy only moves when a word is taken in
  a_occ_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != $past(occ_r)) |-> $past(in_valid && in_ready))
    else $error("heap occupancy changed without an input word");

  // words without a record carry zero record fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != wpmh_pkg::ST_EXTRACTED)) |->
      (out_r.out_age == '0 && out_r.out_contact_tag == '0 &&
       !out_r.out_comorbidity && !out_r.out_risk_area))
    else $error("non-extract result carries record data");

  // the sifting machinery never writes the ram while idle without a word
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !in_fire) |-> !we)
    else $error("heap ram written while idle");

endmodule
